FILE: rtl/svrt_pkg.sv
`default_nettype none

package svrt_pkg;

   // oscillator geometry
   localparam int PHASE_BITS   = 32;
   localparam int SINE_ENTRIES = 1024;
   localparam int IDX_BITS     = $clog2(SINE_ENTRIES);
   localparam int TURN_W       = 16;
   localparam int TURN_SHIFT   = TURN_W - IDX_BITS;

   // field and register widths
   localparam int SCALE_W   = 40;
   localparam int SCALE_LO  = 32;
   localparam int NOTE_W    = 7;
   localparam int VEL_W     = 7;
   localparam int SAMPLE_W  = 16;
   localparam int LEVEL_W   = 13;
   localparam int TAIL_W    = 17;
   localparam int X_W       = 15;
   localparam int FREQ_W    = 26;
   localparam int BASE_W    = 26;
   localparam int OCT_W     = 4;
   localparam int P_W       = 32;
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = FREQ_W;
   localparam int MUL_W     = MUL_A_W + MUL_B_W;
   localparam int STEP_SUM_W = 64;
   localparam int STEP_LSB  = STEP_SUM_W - PHASE_BITS;
   localparam int PC_W      = 5;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd93824992237;

   // quarter-wave sine polynomial, Q28 coefficients
   localparam logic [P_W-1:0] POLY_C3 = 32'd1256748;
   localparam logic [P_W-1:0] POLY_C2 = 32'd21392333;
   localparam logic [P_W-1:0] POLY_C1 = 32'd173399668;
   localparam logic [P_W-1:0] POLY_C0 = 32'd421657428;
   localparam logic [X_W-1:0] QUARTER = 15'd16384;

   localparam logic [TAIL_W-1:0] TAIL_ONE   = 17'd65536;
   localparam logic [15:0]       TAIL_DECAY = 16'd64881;
   localparam logic [TAIL_W-1:0] TAIL_STOP  = 17'd327;
   localparam logic [31:0]       HALF_Q31   = 32'h4000_0000;
   localparam logic [15:0]       SAMPLE_MAX = 16'd32767;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_ON       = 2'd1,
      REQ_OFF_TAIL = 2'd2,
      REQ_OFF_NOW  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      MA_NONE, MA_X, MA_P, MA_TAIL, MA_C3, MA_SCALE_LO, MA_SCALE_HI
   } ma_type;

   typedef enum logic [2:0] {
      MB_NONE, MB_X, MB_X2, MB_DECAY, MB_LEVEL, MB_TAIL, MB_P
   } mb_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_X2, WB_TDEC, WB_POLY_C2, WB_POLY_C1, WB_POLY_C0, WB_MAG, WB_PROD,
      WB_ACC, WB_STEP, WB_NOTE, WB_ARM, WB_OFF, WB_EMIT_TAIL, WB_EMIT_PLAIN,
      WB_EMIT_SILENT
   } wb_type;

   typedef enum logic [1:0] {
      JC_NONE, JC_SILENT, JC_NO_TAIL
   } jc_type;

   typedef enum logic {
      SEQ_IDLE, SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      ma_type          ma;
      mb_type          mb;
      wb_type          wb;
      jc_type          jc;
      logic [PC_W-1:0] target;
      logic            emit;
      logic            last;
   } uword_type;

   typedef struct packed {
      logic voice_on;
      logic tail_zero;
      logic out_free;
   } seq_cond_type;

   typedef struct packed {
      logic busy;
      logic go;
   } seq_ctl_type;

   // microcode addresses
   localparam logic [PC_W-1:0] U_SQUARE      = 5'd0;
   localparam logic [PC_W-1:0] U_DECAY       = 5'd1;
   localparam logic [PC_W-1:0] U_HORNER3     = 5'd2;
   localparam logic [PC_W-1:0] U_SUB2        = 5'd3;
   localparam logic [PC_W-1:0] U_HORNER2     = 5'd4;
   localparam logic [PC_W-1:0] U_SUB1        = 5'd5;
   localparam logic [PC_W-1:0] U_HORNER1     = 5'd6;
   localparam logic [PC_W-1:0] U_SUB0        = 5'd7;
   localparam logic [PC_W-1:0] U_TIMES_X     = 5'd8;
   localparam logic [PC_W-1:0] U_MAG         = 5'd9;
   localparam logic [PC_W-1:0] U_LEVEL       = 5'd10;
   localparam logic [PC_W-1:0] U_PROD        = 5'd11;
   localparam logic [PC_W-1:0] U_TAIL        = 5'd12;
   localparam logic [PC_W-1:0] U_EMIT_TAIL   = 5'd13;
   localparam logic [PC_W-1:0] U_EMIT_PLAIN  = 5'd14;
   localparam logic [PC_W-1:0] U_EMIT_SILENT = 5'd15;
   localparam logic [PC_W-1:0] U_NOTE        = 5'd16;
   localparam logic [PC_W-1:0] U_STEP_LO     = 5'd17;
   localparam logic [PC_W-1:0] U_STEP_HI     = 5'd18;
   localparam logic [PC_W-1:0] U_STEP        = 5'd19;
   localparam logic [PC_W-1:0] U_ARM         = 5'd20;
   localparam logic [PC_W-1:0] U_OFF         = 5'd21;

   function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] kind);
      logic [PC_W-1:0] pc;
      case (kind)
         REQ_TICK:     pc = U_SQUARE;
         REQ_ON:       pc = U_NOTE;
         REQ_OFF_TAIL: pc = U_ARM;
         REQ_OFF_NOW:  pc = U_OFF;
         default:      pc = U_OFF;
      endcase
      return pc;
   endfunction

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w.ma     = MA_NONE;
      w.mb     = MB_NONE;
      w.wb     = WB_NONE;
      w.jc     = JC_NONE;
      w.target = '0;
      w.emit   = 1'b0;
      w.last   = 1'b0;
      case (pc)
         U_SQUARE: begin
            w.ma = MA_X; w.mb = MB_X; w.jc = JC_SILENT; w.target = U_EMIT_SILENT;
         end
         U_DECAY: begin
            w.ma = MA_TAIL; w.mb = MB_DECAY; w.wb = WB_X2;
         end
         U_HORNER3: begin
            w.ma = MA_C3; w.mb = MB_X2; w.wb = WB_TDEC;
         end
         U_SUB2:    w.wb = WB_POLY_C2;
         U_HORNER2: begin
            w.ma = MA_P; w.mb = MB_X2;
         end
         U_SUB1:    w.wb = WB_POLY_C1;
         U_HORNER1: begin
            w.ma = MA_P; w.mb = MB_X2;
         end
         U_SUB0:    w.wb = WB_POLY_C0;
         U_TIMES_X: begin
            w.ma = MA_P; w.mb = MB_X;
         end
         U_MAG:     w.wb = WB_MAG;
         U_LEVEL: begin
            w.ma = MA_P; w.mb = MB_LEVEL;
         end
         U_PROD: begin
            w.wb = WB_PROD; w.jc = JC_NO_TAIL; w.target = U_EMIT_PLAIN;
         end
         U_TAIL: begin
            w.ma = MA_P; w.mb = MB_TAIL;
         end
         U_EMIT_TAIL: begin
            w.wb = WB_EMIT_TAIL; w.emit = 1'b1; w.last = 1'b1;
         end
         U_EMIT_PLAIN: begin
            w.wb = WB_EMIT_PLAIN; w.emit = 1'b1; w.last = 1'b1;
         end
         U_EMIT_SILENT: begin
            w.wb = WB_EMIT_SILENT; w.emit = 1'b1; w.last = 1'b1;
         end
         U_NOTE:    w.wb = WB_NOTE;
         U_STEP_LO: begin
            w.ma = MA_SCALE_LO; w.mb = MB_P;
         end
         U_STEP_HI: begin
            w.ma = MA_SCALE_HI; w.mb = MB_P; w.wb = WB_ACC;
         end
         U_STEP: begin
            w.wb = WB_STEP; w.last = 1'b1;
         end
         U_ARM: begin
            w.wb = WB_ARM; w.last = 1'b1;
         end
         U_OFF: begin
            w.wb = WB_OFF; w.last = 1'b1;
         end
         default:   w.last = 1'b1;
      endcase
      return w;
   endfunction

   // note base frequencies of the lowest octave, Q22
   function automatic logic [BASE_W-1:0] base_q22(input logic [3:0] semi);
      logic [BASE_W-1:0] f;
      case (semi)
         4'd0:    f = 26'd34291786;
         4'd1:    f = 26'd36330882;
         4'd2:    f = 26'd38491228;
         4'd3:    f = 26'd40780036;
         4'd4:    f = 26'd43204943;
         4'd5:    f = 26'd45774043;
         4'd6:    f = 26'd48495909;
         4'd7:    f = 26'd51379626;
         4'd8:    f = 26'd54434817;
         4'd9:    f = 26'd57671680;
         4'd10:   f = 26'd61101017;
         4'd11:   f = 26'd64734272;
         default: f = '0;
      endcase
      return f;
   endfunction

   typedef logic [127:0][LEVEL_W-1:0] level_rom_type;

   // 0.15 * v / 127 in Q0.15, rounded
   function automatic level_rom_type level_rom_build();
      level_rom_type r;
      for (int i = 0; i < 128; i++) begin
         r[i] = LEVEL_W'((i * 49152 + 635) / 1270);
      end
      return r;
   endfunction

   localparam level_rom_type LEVEL_ROM = level_rom_build();

   function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [31:0] mag,
                                                      input logic neg);
      logic [SAMPLE_W-1:0] m;
      m = (mag > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : mag[SAMPLE_W-1:0];
      return neg ? SAMPLE_W'(16'd0 - m) : m;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/svrt_seq.sv
`default_nettype none

module svrt_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              kind,
   input  svrt_pkg::seq_cond_type  cond,
   output svrt_pkg::uword_type     uw,
   output svrt_pkg::seq_ctl_type   ctl
);

   svrt_pkg::seq_state_type state_ff, state_in;
   logic [svrt_pkg::PC_W-1:0] pc_ff, pc_in;
   logic taken;
   logic hold;

   assign uw = svrt_pkg::ucode(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svrt_pkg::SEQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (uw.jc)
         svrt_pkg::JC_SILENT:  taken = !cond.voice_on;
         svrt_pkg::JC_NO_TAIL: taken = cond.tail_zero;
         default:              taken = 1'b0;
      endcase
      // a result step waits until the output register can take it
      hold     = uw.emit && !cond.out_free;
      ctl.busy = (state_ff == svrt_pkg::SEQ_RUN);
      ctl.go   = 1'b0;
      case (state_ff)
         svrt_pkg::SEQ_IDLE: begin
            if (start) begin
               state_in = svrt_pkg::SEQ_RUN;
               pc_in    = svrt_pkg::entry_pc(kind);
            end
         end
         svrt_pkg::SEQ_RUN: begin
            ctl.go = !hold;
            if (!hold) begin
               if (uw.last) begin
                  state_in = svrt_pkg::SEQ_IDLE;
               end else if (taken) begin
                  pc_in = uw.target;
               end else begin
                  pc_in = pc_ff + 5'd1;
               end
            end
         end
         default: state_in = svrt_pkg::SEQ_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/sine_voice_with_release_tail_top.sv
`default_nettype none

// channel  direction  handshake          payload
// req      in         req_valid/stall    req_type, req_note, req_velocity
// rsp      out        rsp_valid/stall    rsp_sample, rsp_note_active
// csr      in         csr_valid/ready    csr_phase_scale
//
// the microcode program drives one shared 32x26 multiplier
// through the Horner chain of the sine polynomial
// synchronous reset clears the voice and the sequencer and loads the scale register with its reset value
// a held result on rsp does not block the next req transaction, only the next result

module sine_voice_with_release_tail_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [svrt_pkg::NOTE_W-1:0]         req_note,
   input  logic [svrt_pkg::VEL_W-1:0]          req_velocity,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [svrt_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                rsp_note_active,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [svrt_pkg::SCALE_W-1:0]        csr_phase_scale
);

   svrt_pkg::uword_type    uw;
   svrt_pkg::seq_cond_type cond;
   svrt_pkg::seq_ctl_type  ctl;
   logic start;

   // voice state
   logic [svrt_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic [svrt_pkg::PHASE_BITS-1:0] step_ff, step_in;
   logic [svrt_pkg::LEVEL_W-1:0]    level_ff, level_in;
   logic [svrt_pkg::TAIL_W-1:0]     tail_ff, tail_in;
   logic                            voice_ff, voice_in;
   logic [svrt_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [svrt_pkg::NOTE_W-1:0]   note_ff, note_in;
   logic [svrt_pkg::VEL_W-1:0]    vel_ff, vel_in;
   logic [svrt_pkg::X_W-1:0]      x_ff, x_in;
   logic                          neg_ff, neg_in;
   logic [svrt_pkg::X_W-1:0]      x2_ff, x2_in;
   logic [svrt_pkg::TAIL_W-1:0]   tdec_ff, tdec_in;
   logic [svrt_pkg::P_W-1:0]      p_ff, p_in;
   logic [svrt_pkg::MUL_W-1:0]    acc_ff, acc_in;
   logic [svrt_pkg::MUL_W-1:0]    mul_ff, mul_in;
   logic [svrt_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                          active_ff, active_in;

   logic [svrt_pkg::TURN_W-1:0]     turn;
   logic [svrt_pkg::X_W-1:0]        x_new;
   logic [14:0]                     oct_prod;
   logic [svrt_pkg::OCT_W-1:0]      oct;
   logic [svrt_pkg::NOTE_W-1:0]     oct_base;
   logic [3:0]                      semi;
   logic [36:0]                     freq_wide;
   logic [svrt_pkg::FREQ_W-1:0]     freq;
   logic [svrt_pkg::MUL_A_W-1:0]    mul_a;
   logic [svrt_pkg::MUL_B_W-1:0]    mul_b;
   logic [svrt_pkg::MUL_W-1:0]      tdec_sum;
   logic [svrt_pkg::MUL_W-1:0]      mag_sum;
   logic [svrt_pkg::MUL_W-1:0]      rnd_tail_sum;
   logic [32:0]                     rnd_plain_sum;
   logic [svrt_pkg::STEP_SUM_W-1:0] step_sum;
   logic                            tdec_alive;

   svrt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_type),
      .cond  (cond),
      .uw    (uw),
      .ctl   (ctl)
   );

   assign start           = req_valid && !req_stall;
   assign req_stall       = ctl.busy;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = signed'(sample_ff);
   assign rsp_note_active = active_ff;

   assign cond.voice_on  = voice_ff;
   assign cond.tail_zero = (tail_ff == '0);
   assign cond.out_free  = !rsp_valid_ff || !rsp_stall;

   // quarter-wave argument from the table index
   assign turn  = svrt_pkg::TURN_W'(phase_ff[svrt_pkg::PHASE_BITS-1 -: svrt_pkg::IDX_BITS])
                  << svrt_pkg::TURN_SHIFT;
   assign x_new = turn[14] ? (svrt_pkg::QUARTER - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};

   // octave by multiplying with 171/2048, exact for seven-bit notes
   assign oct_prod  = 15'(note_ff) * 15'd171;
   assign oct       = oct_prod[14:11];
   assign oct_base  = 7'(oct) * 7'd12;
   assign semi      = 4'(note_ff - oct_base);
   assign freq_wide = ((37'(svrt_pkg::base_q22(semi)) << oct) + 37'd512) >> 10;
   assign freq      = freq_wide[svrt_pkg::FREQ_W-1:0];

   always_comb begin
      case (uw.ma)
         svrt_pkg::MA_X:        mul_a = 32'(x_ff);
         svrt_pkg::MA_P:        mul_a = p_ff;
         svrt_pkg::MA_TAIL:     mul_a = 32'(tail_ff);
         svrt_pkg::MA_C3:       mul_a = svrt_pkg::POLY_C3;
         svrt_pkg::MA_SCALE_LO: mul_a = scale_ff[svrt_pkg::SCALE_LO-1:0];
         svrt_pkg::MA_SCALE_HI: mul_a = 32'(scale_ff[svrt_pkg::SCALE_W-1:svrt_pkg::SCALE_LO]);
         default:               mul_a = '0;
      endcase
      case (uw.mb)
         svrt_pkg::MB_X:     mul_b = 26'(x_ff);
         svrt_pkg::MB_X2:    mul_b = 26'(x2_ff);
         svrt_pkg::MB_DECAY: mul_b = 26'(svrt_pkg::TAIL_DECAY);
         svrt_pkg::MB_LEVEL: mul_b = 26'(level_ff);
         svrt_pkg::MB_TAIL:  mul_b = 26'(tail_ff);
         svrt_pkg::MB_P:     mul_b = p_ff[svrt_pkg::FREQ_W-1:0];
         default:            mul_b = '0;
      endcase
   end

   assign tdec_sum      = mul_ff + svrt_pkg::MUL_W'(32768);
   assign mag_sum       = (mul_ff >> 14) + svrt_pkg::MUL_W'(4096);
   assign rnd_tail_sum  = mul_ff + svrt_pkg::MUL_W'(svrt_pkg::HALF_Q31);
   assign rnd_plain_sum = 33'(p_ff) + 33'd16384;
   assign step_sum      = svrt_pkg::STEP_SUM_W'(acc_ff)
                          + (svrt_pkg::STEP_SUM_W'(mul_ff) << svrt_pkg::SCALE_LO);
   assign tdec_alive    = tdec_ff > svrt_pkg::TAIL_STOP;

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      level_in     = level_ff;
      tail_in      = tail_ff;
      voice_in     = voice_ff;
      scale_in     = scale_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      note_in      = note_ff;
      vel_in       = vel_ff;
      x_in         = x_ff;
      neg_in       = neg_ff;
      x2_in        = x2_ff;
      tdec_in      = tdec_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      mul_in       = mul_ff;
      sample_in    = sample_ff;
      active_in    = active_ff;

      if (csr_valid && csr_ready) begin
         scale_in = csr_phase_scale;
      end

      if (start) begin
         note_in = req_note;
         vel_in  = req_velocity;
         x_in    = x_new;
         neg_in  = turn[15];
      end

      if (ctl.go) begin
         mul_in = mul_a * mul_b;
         case (uw.wb)
            svrt_pkg::WB_X2:      x2_in   = svrt_pkg::X_W'(mul_ff >> 14);
            svrt_pkg::WB_TDEC:    tdec_in = svrt_pkg::TAIL_W'(tdec_sum >> 16);
            svrt_pkg::WB_POLY_C2: p_in    = svrt_pkg::POLY_C2 - 32'(mul_ff >> 14);
            svrt_pkg::WB_POLY_C1: p_in    = svrt_pkg::POLY_C1 - 32'(mul_ff >> 14);
            svrt_pkg::WB_POLY_C0: p_in    = svrt_pkg::POLY_C0 - 32'(mul_ff >> 14);
            svrt_pkg::WB_MAG:     p_in    = 32'(mag_sum >> 13);
            svrt_pkg::WB_PROD:    p_in    = mul_ff[svrt_pkg::P_W-1:0];
            svrt_pkg::WB_ACC:     acc_in  = mul_ff;
            svrt_pkg::WB_STEP: begin
               step_in = step_sum[svrt_pkg::STEP_LSB +: svrt_pkg::PHASE_BITS];
            end
            svrt_pkg::WB_NOTE: begin
               p_in     = 32'(freq);
               level_in = svrt_pkg::LEVEL_ROM[vel_ff];
               phase_in = '0;
               tail_in  = '0;
               voice_in = 1'b1;
            end
            svrt_pkg::WB_ARM: begin
               if (tail_ff == '0) begin
                  tail_in = svrt_pkg::TAIL_ONE;
               end
            end
            svrt_pkg::WB_OFF: voice_in = 1'b0;
            svrt_pkg::WB_EMIT_TAIL: begin
               rsp_valid_in = 1'b1;
               sample_in    = svrt_pkg::sat_sample(32'(rnd_tail_sum >> 31), neg_ff);
               phase_in     = phase_ff + step_ff;
               tail_in      = tdec_ff;
               voice_in     = tdec_alive;
               active_in    = tdec_alive;
            end
            svrt_pkg::WB_EMIT_PLAIN: begin
               rsp_valid_in = 1'b1;
               sample_in    = svrt_pkg::sat_sample(32'(rnd_plain_sum >> 15), neg_ff);
               phase_in     = phase_ff + step_ff;
               active_in    = voice_ff;
            end
            svrt_pkg::WB_EMIT_SILENT: begin
               rsp_valid_in = 1'b1;
               sample_in    = '0;
               active_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         step_ff      <= '0;
         level_ff     <= '0;
         tail_ff      <= '0;
         voice_ff     <= 1'b0;
         scale_ff     <= svrt_pkg::SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         tail_ff      <= tail_in;
         voice_ff     <= voice_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff   <= note_in;
      vel_ff    <= vel_in;
      x_ff      <= x_in;
      neg_ff    <= neg_in;
      x2_ff     <= x2_in;
      tdec_ff   <= tdec_in;
      p_ff      <= p_in;
      acc_ff    <= acc_in;
      mul_ff    <= mul_in;
      sample_ff <= sample_in;
      active_ff <= active_in;
   end

   // a result step never overwrites a transaction still held on rsp
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.go && uw.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result step ran while output held");

   // new results come only from a result step of the program
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.go && uw.emit))
      else $error("result appeared without a result step");

   // a sounding voice with a tail always has the tail above the stop level
   a_tail_alive: assert property (@(posedge clock) disable iff (reset)
      voice_ff && (tail_ff != '0) |-> tail_ff > svrt_pkg::TAIL_STOP)
      else $error("voice sounding with an expired tail");

endmodule

`default_nettype wire
